// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk; TVS_ASSERT is quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop on every rising edge of clk while rst_n is high.
`define TVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks prop on every rising edge of clk, reset included.
`define TVS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tvs_pkg.sv -----
// ----------------------------------------------------------------------------
// tvs_pkg
// Constants and helper functions for the trapezoidal velocity step.
// ----------------------------------------------------------------------------
package tvs_pkg;

  localparam int unsigned ROBOTS_PER_TEAM_DEF = 8;

  localparam logic [2:0] REG_MAX_ACCEL      = 3'd0;
  localparam logic [2:0] REG_MAX_TURN_ACCEL = 3'd1;
  localparam logic [2:0] REG_MAX_SPEED      = 3'd2;
  localparam logic [2:0] REG_MAX_TURN_RATE  = 3'd3;
  localparam logic [2:0] REG_TIME_STEP      = 3'd4;

  localparam logic [30:0] MAX_ACCEL_RST      = 31'd196608;
  localparam logic [30:0] MAX_TURN_ACCEL_RST = 31'd393216;
  localparam logic [30:0] MAX_SPEED_RST      = 31'd131072;
  localparam logic [30:0] MAX_TURN_RATE_RST  = 31'd262144;
  localparam logic [15:0] TIME_STEP_RST      = 16'd1092;

  localparam logic [31:0] REACH_LIMIT = 32'd3277;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat_diff(input logic [31:0] t, input logic [31:0] p);
    logic signed [32:0] diff;
    diff = $signed({t[31], t}) - $signed({p[31], p});
    if (diff > 33'sh0_7FFF_FFFF) begin
      sat_diff = 32'h7FFF_FFFF;
    end else if (diff < -33'sh0_7FFF_FFFF) begin
      sat_diff = 32'h8000_0001;
    end else begin
      sat_diff = diff[31:0];
    end
  endfunction

  function automatic logic [31:0] accel_update(input logic [31:0] v, input logic neg,
                                               input logic [30:0] delta,
                                               input logic [30:0] lim);
    logic signed [33:0] nv;
    logic signed [33:0] l;
    nv = $signed({{2{v[31]}}, v});
    l  = $signed({3'b000, lim});
    if (neg) begin
      nv = nv - $signed({3'b000, delta});
    end else begin
      nv = nv + $signed({3'b000, delta});
    end
    if (nv > l) begin
      nv = l;
    end else if (nv < -l) begin
      nv = -l;
    end
    accel_update = nv[31:0];
  endfunction

  function automatic logic [31:0] brake_update(input logic [31:0] v, input logic [30:0] delta);
    logic [31:0] d;
    d = {1'b0, delta};
    if (v[31]) begin
      brake_update = v + d;
    end else if (v != 32'd0) begin
      brake_update = v - d;
    end else begin
      brake_update = 32'd0;
    end
  endfunction

endpackage

// ----- rtl/tvs_isqrt.sv -----
// ----------------------------------------------------------------------------
// tvs_isqrt
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tvs_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x_r, x_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] trial;

  always_comb begin
    trial    = r_r + bit_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      r_nxt    = 64'd0;
      bit_nxt  = 64'd1 << 62;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_nxt = x_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

// ----- rtl/tvs_div.sv -----
// ----------------------------------------------------------------------------
// tvs_div
// Restoring divider for a 62-bit dividend whose quotient fits in 31 bits.
// ----------------------------------------------------------------------------
module tvs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [30:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [30:0] low_r, low_nxt;
  logic [30:0] q_r, q_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    trial    = {rem_r, low_r[30]};
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, dividend[61:31]};
      low_nxt  = dividend[30:0];
      q_nxt    = 31'd0;
      dv_nxt   = divisor;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt = 32'(trial - {1'b0, dv_r});
        q_nxt   = {q_r[29:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[29:0], 1'b0};
      end
      low_nxt = {low_r[29:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd30) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- rtl/trapezoidal_velocity_step.sv -----
// ----------------------------------------------------------------------------
// trapezoidal_velocity_step
// One item updates the stored velocity of one in-range robot toward a target pose.
// How long an item takes depends on its path: the robot accelerates, brakes,
// has reached the target, or has a robot index out of range. The squaring
// steps, the square root and, when accelerating, three divisions set this;
// the squares and other products come from one shared multiplier. A new item
// is taken once the previous one has gone into the output register.
// ----------------------------------------------------------------------------
module trapezoidal_velocity_step #(
  parameter int unsigned ROBOTS_PER_TEAM = tvs_pkg::ROBOTS_PER_TEAM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_robot_index,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_heading,
  input  logic [31:0] in_pose_x,
  input  logic [31:0] in_pose_y,
  input  logic [31:0] in_pose_heading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_robot_id,
  output logic        out_reached,
  output logic        out_braking,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_vel_turn
);

`include "assert_macros.svh"

  localparam int unsigned IDXW = (ROBOTS_PER_TEAM > 1) ? $clog2(ROBOTS_PER_TEAM) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQS, S_SQRT, S_NRM, S_CMP, S_STEPW,
    S_AMUL, S_ADIVS, S_ADIV, S_BMUL, S_BUPD, S_FIN
  } state_t;

  state_t      state_r, state_nxt;
  logic [30:0] max_accel_r, max_turn_accel_r, max_speed_r, max_turn_rate_r;
  logic [15:0] time_step_r;

  logic [31:0] vx_store_r [ROBOTS_PER_TEAM];
  logic [31:0] vy_store_r [ROBOTS_PER_TEAM];
  logic [31:0] vt_store_r [ROBOTS_PER_TEAM];

  logic [2:0]      rid_r, rid_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic            inr_r, inr_nxt;
  logic [31:0]     d_r [3];
  logic [31:0]     d_nxt [3];
  logic [31:0]     v_r [3];
  logic [31:0]     v_nxt [3];
  logic [63:0]     sum_r, sum_nxt;
  logic [63:0]     vsq_r, vsq_nxt;
  logic [31:0]     norm_r, norm_nxt;
  logic [30:0]     step_r, step_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            reached_r, reached_nxt;
  logic            braking_r, braking_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [30:0] div_q;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_rid_r, out_rid_nxt;
  logic        out_reached_r, out_reached_nxt;
  logic        out_braking_r, out_braking_nxt;
  logic [31:0] out_vx_r, out_vx_nxt, out_vy_r, out_vy_nxt, out_vt_r, out_vt_nxt;
  logic        store_we;

  logic        in_acc;
  logic        in_range;
  logic [1:0]  ci;
  logic [30:0] acc_sel;
  logic [30:0] lim_sel;
  logic [31:0] vmag;
  logic [31:0] dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = ({2'b00, in_robot_index} < 5'(ROBOTS_PER_TEAM));
  assign ci        = cnt_r[1:0];

  always_comb begin
    acc_sel = (ci == 2'd2) ? max_turn_accel_r : max_accel_r;
    lim_sel = (ci == 2'd2) ? max_turn_rate_r : max_speed_r;
    vmag    = tvs_pkg::mag32(v_r[ci]);
    dec     = (vmag < {1'b0, acc_sel}) ? vmag : {1'b0, acc_sel};
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_SQ: begin
        if (cnt_r < 3'd3) begin
          mul_a = tvs_pkg::mag32(d_r[ci]);
        end else if (cnt_r < 3'd6) begin
          mul_a = tvs_pkg::mag32(v_r[2'(cnt_r - 3'd3)]);
        end
        mul_b = mul_a;
      end
      S_NRM: begin
        mul_a = norm_r;
        mul_b = {max_accel_r, 1'b0};
      end
      S_CMP: begin
        mul_a = {1'b0, max_accel_r};
        mul_b = {16'd0, time_step_r};
      end
      S_AMUL: begin
        mul_a = {1'b0, step_r};
        mul_b = tvs_pkg::mag32(d_r[ci]);
      end
      S_BMUL: begin
        mul_a = dec;
        mul_b = {16'd0, time_step_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  tvs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  tvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r[61:0]),
    .divisor  (norm_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sqrt_start = (state_r == S_SQS);
  assign div_start  = (state_r == S_ADIVS);

  always_comb begin
    state_nxt       = state_r;
    rid_nxt         = rid_r;
    idx_nxt         = idx_r;
    inr_nxt         = inr_r;
    d_nxt           = d_r;
    v_nxt           = v_r;
    sum_nxt         = sum_r;
    vsq_nxt         = vsq_r;
    norm_nxt        = norm_r;
    step_nxt        = step_r;
    cnt_nxt         = cnt_r;
    reached_nxt     = reached_r;
    braking_nxt     = braking_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_rid_nxt     = out_rid_r;
    out_reached_nxt = out_reached_r;
    out_braking_nxt = out_braking_r;
    out_vx_nxt      = out_vx_r;
    out_vy_nxt      = out_vy_r;
    out_vt_nxt      = out_vt_r;
    store_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rid_nxt     = in_robot_index;
          idx_nxt     = IDXW'(in_robot_index);
          inr_nxt     = in_range;
          d_nxt[0]    = tvs_pkg::sat_diff(in_target_x, in_pose_x);
          d_nxt[1]    = tvs_pkg::sat_diff(in_target_y, in_pose_y);
          d_nxt[2]    = tvs_pkg::sat_diff(in_target_heading, in_pose_heading);
          sum_nxt     = 64'd0;
          vsq_nxt     = 64'd0;
          cnt_nxt     = 3'd0;
          reached_nxt = 1'b0;
          braking_nxt = 1'b0;
          if (in_range) begin
            v_nxt[0]  = vx_store_r[IDXW'(in_robot_index)];
            v_nxt[1]  = vy_store_r[IDXW'(in_robot_index)];
            v_nxt[2]  = vt_store_r[IDXW'(in_robot_index)];
            state_nxt = S_SQ;
          end else begin
            v_nxt[0]  = 32'd0;
            v_nxt[1]  = 32'd0;
            v_nxt[2]  = 32'd0;
            state_nxt = S_FIN;
          end
        end
      end
      S_SQ: begin
        if (cnt_r != 3'd0) begin
          if (cnt_r <= 3'd3) begin
            sum_nxt = sum_r + prod_r;
          end else begin
            vsq_nxt = vsq_r + prod_r;
          end
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          state_nxt = S_SQS;
        end
      end
      S_SQS: begin
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sqrt_done) begin
          norm_nxt  = sqrt_root;
          state_nxt = S_NRM;
        end
      end
      S_NRM: begin
        if (norm_r < tvs_pkg::REACH_LIMIT) begin
          reached_nxt = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cnt_nxt = 3'd0;
        if (prod_r > vsq_r) begin
          state_nxt = S_STEPW;
        end else begin
          braking_nxt = 1'b1;
          state_nxt   = S_BMUL;
        end
      end
      S_STEPW: begin
        step_nxt  = prod_r[46:16];
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        state_nxt = S_ADIVS;
      end
      S_ADIVS: begin
        state_nxt = S_ADIV;
      end
      S_ADIV: begin
        if (div_done) begin
          v_nxt[ci] = tvs_pkg::accel_update(v_r[ci], d_r[ci][31], div_q, lim_sel);
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = (cnt_r == 3'd2) ? S_FIN : S_AMUL;
        end
      end
      S_BMUL: begin
        state_nxt = S_BUPD;
      end
      S_BUPD: begin
        v_nxt[ci] = tvs_pkg::brake_update(v_r[ci], prod_r[46:16]);
        cnt_nxt   = cnt_r + 3'd1;
        state_nxt = (cnt_r == 3'd2) ? S_FIN : S_BMUL;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_rid_nxt     = rid_r;
          out_reached_nxt = reached_r;
          out_braking_nxt = braking_r;
          out_vx_nxt      = v_r[0];
          out_vy_nxt      = v_r[1];
          out_vt_nxt      = v_r[2];
          store_we        = inr_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rid_r         <= rid_nxt;
    idx_r         <= idx_nxt;
    d_r           <= d_nxt;
    v_r           <= v_nxt;
    sum_r         <= sum_nxt;
    vsq_r         <= vsq_nxt;
    norm_r        <= norm_nxt;
    step_r        <= step_nxt;
    cnt_r         <= cnt_nxt;
    reached_r     <= reached_nxt;
    braking_r     <= braking_nxt;
    inr_r         <= inr_nxt;
    out_rid_r     <= out_rid_nxt;
    out_reached_r <= out_reached_nxt;
    out_braking_r <= out_braking_nxt;
    out_vx_r      <= out_vx_nxt;
    out_vy_r      <= out_vy_nxt;
    out_vt_r      <= out_vt_nxt;
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      max_accel_r      <= tvs_pkg::MAX_ACCEL_RST;
      max_turn_accel_r <= tvs_pkg::MAX_TURN_ACCEL_RST;
      max_speed_r      <= tvs_pkg::MAX_SPEED_RST;
      max_turn_rate_r  <= tvs_pkg::MAX_TURN_RATE_RST;
      time_step_r      <= tvs_pkg::TIME_STEP_RST;
      for (int i = 0; i < ROBOTS_PER_TEAM; i++) begin
        vx_store_r[i] <= 32'd0;
        vy_store_r[i] <= 32'd0;
        vt_store_r[i] <= 32'd0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tvs_pkg::REG_MAX_ACCEL:      max_accel_r      <= cfg_data[30:0];
          tvs_pkg::REG_MAX_TURN_ACCEL: max_turn_accel_r <= cfg_data[30:0];
          tvs_pkg::REG_MAX_SPEED:      max_speed_r      <= cfg_data[30:0];
          tvs_pkg::REG_MAX_TURN_RATE:  max_turn_rate_r  <= cfg_data[30:0];
          tvs_pkg::REG_TIME_STEP:      time_step_r      <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (store_we) begin
        vx_store_r[idx_r] <= v_r[0];
        vy_store_r[idx_r] <= v_r[1];
        vt_store_r[idx_r] <= v_r[2];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_robot_id = out_rid_r;
  assign out_reached  = out_reached_r;
  assign out_braking  = out_braking_r;
  assign out_vel_x    = out_vx_r;
  assign out_vel_y    = out_vy_r;
  assign out_vel_turn = out_vt_r;

  `TVS_ASSERT(a_busy_after_accept, in_acc |=> in_stall, "block ready right after taking an item")
  `TVS_ASSERT(a_flags_exclusive, out_valid |-> !(out_reached && out_braking), "reached and braking both set")
  `TVS_ASSERT(a_store_write_at_finish, store_we |-> (state_r == S_FIN) && (state_nxt == S_IDLE), "velocity written outside finish")

endmodule
